### rtl/haar_quadtree_point_store_macros.svh
// ----------------------------------------------------------------------------
// Haar quadtree point store: assertion macros
// Shared concurrent check forms for the point store RTL.
// ----------------------------------------------------------------------------
`ifndef HAAR_QUADTREE_POINT_STORE_MACROS_SVH
`define HAAR_QUADTREE_POINT_STORE_MACROS_SVH

// same-cycle implication
`define HQPS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("haar quadtree store: same-cycle check failed");

// next-cycle implication
`define HQPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("haar quadtree store: next-cycle check failed");

`endif

### rtl/hqps_pkg.sv
// ----------------------------------------------------------------------------
// Haar quadtree point store package
// Coefficient types, request codes and node layout helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hqps_pkg;

    localparam int CW         = 48;
    localparam int VW         = 32;
    localparam int FRAC_SHIFT = 10;

    typedef logic [CW-1:0] coef_t;
    typedef logic [VW-1:0] value_t;

    typedef enum logic [1:0] {
        REQ_QUERY = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_SET   = 2'd2,
        REQ_ALT   = 2'd3
    } req_t;

    // first node index of a tree level: (4^lvl - 1) / 3
    function automatic logic [15:0] node_base(input logic [2:0] lvl);
        logic [15:0] b;
        unique case (lvl)
            3'd0: b = 16'd0;
            3'd1: b = 16'd1;
            3'd2: b = 16'd5;
            3'd3: b = 16'd21;
            3'd4: b = 16'd85;
            3'd5: b = 16'd341;
            3'd6: b = 16'd1365;
            3'd7: b = 16'd5461;
            default: b = 16'd0;
        endcase
        return b;
    endfunction

    function automatic coef_t neg_if(input coef_t v, input logic n);
        return n ? (CW'(0) - v) : v;
    endfunction

    function automatic coef_t asr2(input coef_t v);
        return {{2{v[CW-1]}}, v[CW-1:2]};
    endfunction

endpackage

`default_nettype wire

### rtl/hqps_ram.sv
// ----------------------------------------------------------------------------
// Haar quadtree point store RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hqps_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 341
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/haar_quadtree_point_store.sv
// Query: a read walk over TREE_LEVELS - query_level levels; the root needs none.
// Add: push then read walk; set: read, push, read walks; m_tready stalls hold output.
// One item at a time; the node walk issues one RAM read per cycle, and the
// push is a read-modify-write pipeline over the same single-port-read RAM.
// After reset a clearing pass writes every node, during which s_tready stays low.
// ----------------------------------------------------------------------------
// Haar quadtree point store
// Root average plus H/V/D detail coefficients per node, queried and updated
// by walks over a node RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "haar_quadtree_point_store_macros.svh"

module haar_quadtree_point_store #(
    parameter int TREE_LEVELS = 5
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cell_x[4:0], cell_y[9:5], query_level[12:10], operand_value[44:13]
    input  wire logic [47:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cell_value[31:0]
    output logic      [31:0] m_tdata,
    // saturated[0]
    output logic      [0:0]  m_tuser
);

    localparam int NODE_COUNT = ((1 << (2 * TREE_LEVELS)) - 1) / 3;
    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int LW = $clog2(TREE_LEVELS + 1);
    localparam int CW = hqps_pkg::CW;
    localparam int RW = 3 * CW;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RECON,
        ST_PUSH,
        ST_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [1:0]              kind_reg, kind_next;
    logic [TREE_LEVELS-1:0]  x_reg, x_next;
    logic [TREE_LEVELS-1:0]  y_reg, y_next;
    hqps_pkg::coef_t         val_reg, val_next;
    logic [LW-1:0]           depth_reg, depth_next;
    logic [LW-1:0]           cnt_reg, cnt_next;
    logic                    pushed_reg, pushed_next;
    hqps_pkg::coef_t         acc_reg, acc_next;
    hqps_pkg::coef_t         run_reg, run_next;
    hqps_pkg::coef_t         root_reg, root_next;
    logic                    pv_reg, pv_next;
    logic                    pnx_reg, pnx_next;
    logic                    pny_reg, pny_next;
    logic [AW-1:0]           paddr_reg, paddr_next;
    hqps_pkg::coef_t         pq_reg, pq_next;
    logic                    mv_reg, mv_next;
    hqps_pkg::value_t        mdata_reg, mdata_next;
    logic                    msat_reg, msat_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [RW-1:0]           ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [RW-1:0]           ram_rdata;

    logic [7:0]              in_x8, in_y8;
    logic [2:0]              in_level;
    hqps_pkg::coef_t         in_v48;
    logic [LW-1:0]           lvl_issue;
    logic [AW-1:0]           issue_addr;
    logic [TREE_LEVELS-1:0]  xsh, ysh;
    logic                    nx_issue, ny_issue;
    hqps_pkg::coef_t         q_issue;
    hqps_pkg::coef_t         rd_h, rd_v, rd_d;
    hqps_pkg::coef_t         acc_sum;
    hqps_pkg::coef_t         root_sum;
    logic signed [37:0]      out_wide;
    logic                    out_ovf;
    hqps_pkg::value_t        out_val;
    logic                    recon_issue, push_issue;

    function automatic logic [AW-1:0] node_slot(input logic [LW-1:0] lvl,
                                                input logic [TREE_LEVELS-1:0] x,
                                                input logic [TREE_LEVELS-1:0] y);
        logic [15:0]   px;
        logic [15:0]   py;
        logic [15:0]   sum;
        logic [LW-1:0] sh;
        sh  = LW'(TREE_LEVELS) - lvl;
        px  = 16'(x) >> sh;
        py  = 16'(y) >> sh;
        sum = hqps_pkg::node_base(3'(lvl)) + ((py << lvl) | px);
        return sum[AW-1:0];
    endfunction

    hqps_ram #(
        .WIDTH(RW),
        .DEPTH(NODE_COUNT)
    ) u_node_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = msat_reg;

    assign in_x8    = {3'b000, s_tdata[4:0]};
    assign in_y8    = {3'b000, s_tdata[9:5]};
    assign in_level = s_tdata[12:10];
    assign in_v48   = {{6{s_tdata[44]}}, s_tdata[44:13], 10'b0};

    assign lvl_issue  = (state_reg == ST_PUSH) ? (LW'(TREE_LEVELS - 1) - cnt_reg) : cnt_reg;
    assign issue_addr = node_slot(lvl_issue, x_reg, y_reg);
    assign xsh        = x_reg >> (LW'(TREE_LEVELS - 1) - lvl_issue);
    assign ysh        = y_reg >> (LW'(TREE_LEVELS - 1) - lvl_issue);
    assign nx_issue   = xsh[0];
    assign ny_issue   = ysh[0];
    assign q_issue    = hqps_pkg::asr2(run_reg);

    assign rd_h = ram_rdata[CW-1:0];
    assign rd_v = ram_rdata[2*CW-1:CW];
    assign rd_d = ram_rdata[3*CW-1:2*CW];

    assign acc_sum = acc_reg + hqps_pkg::neg_if(rd_h, pnx_reg)
                   + hqps_pkg::neg_if(rd_v, pny_reg)
                   + hqps_pkg::neg_if(rd_d, pnx_reg ^ pny_reg);
    assign root_sum = root_reg + run_reg;

    assign recon_issue = (cnt_reg < depth_reg);
    assign push_issue  = (cnt_reg < LW'(TREE_LEVELS));

    assign out_wide = $signed(acc_reg[CW-1:hqps_pkg::FRAC_SHIFT]);
    assign out_ovf  = (out_wide[37:31] != {7{out_wide[31]}});
    assign out_val  = out_ovf ? (out_wide[37] ? 32'h8000_0000 : 32'h7fff_ffff)
                              : out_wide[31:0];

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        kind_next   = kind_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        val_next    = val_reg;
        depth_next  = depth_reg;
        cnt_next    = cnt_reg;
        pushed_next = pushed_reg;
        acc_next    = acc_reg;
        run_next    = run_reg;
        root_next   = root_reg;
        pv_next     = 1'b0;
        pnx_next    = pnx_reg;
        pny_next    = pny_reg;
        paddr_next  = paddr_reg;
        pq_next     = pq_reg;
        mv_next     = mv_reg;
        mdata_next  = mdata_reg;
        msat_next   = msat_reg;
        ram_we      = 1'b0;
        ram_waddr   = paddr_reg;
        ram_wdata   = {hqps_pkg::asr2(rd_d) ^ rd_d, rd_v, rd_h};
        ram_re      = 1'b0;
        ram_raddr   = issue_addr;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(NODE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next   = s_tuser;
                    x_next      = in_x8[TREE_LEVELS-1:0];
                    y_next      = in_y8[TREE_LEVELS-1:0];
                    val_next    = in_v48;
                    cnt_next    = '0;
                    pushed_next = 1'b0;
                    acc_next    = root_reg;
                    if (s_tuser == hqps_pkg::REQ_ADD) begin
                        run_next   = in_v48;
                        state_next = ST_PUSH;
                    end else if (s_tuser == hqps_pkg::REQ_SET) begin
                        depth_next = LW'(TREE_LEVELS);
                        state_next = ST_RECON;
                    end else begin
                        depth_next = (int'(in_level) < TREE_LEVELS)
                                   ? LW'(TREE_LEVELS - int'(in_level)) : '0;
                        state_next = ST_RECON;
                    end
                end
            end
            ST_RECON: begin
                if (recon_issue) begin
                    ram_re   = 1'b1;
                    pv_next  = 1'b1;
                    pnx_next = nx_issue;
                    pny_next = ny_issue;
                    cnt_next = cnt_reg + LW'(1);
                end
                if (pv_reg) begin
                    acc_next = acc_sum;
                end
                if (!recon_issue && !pv_reg) begin
                    if (kind_reg == hqps_pkg::REQ_SET && !pushed_reg) begin
                        run_next   = val_reg - acc_reg;
                        cnt_next   = '0;
                        state_next = ST_PUSH;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_PUSH: begin
                if (push_issue) begin
                    ram_re     = 1'b1;
                    pv_next    = 1'b1;
                    pnx_next   = nx_issue;
                    pny_next   = ny_issue;
                    paddr_next = issue_addr;
                    pq_next    = q_issue;
                    run_next   = q_issue;
                    cnt_next   = cnt_reg + LW'(1);
                end
                if (pv_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = paddr_reg;
                    ram_wdata = {rd_d + hqps_pkg::neg_if(pq_reg, pnx_reg ^ pny_reg),
                                 rd_v + hqps_pkg::neg_if(pq_reg, pny_reg),
                                 rd_h + hqps_pkg::neg_if(pq_reg, pnx_reg)};
                end
                if (!push_issue && !pv_reg) begin
                    root_next   = root_sum;
                    acc_next    = root_sum;
                    cnt_next    = '0;
                    depth_next  = LW'(TREE_LEVELS);
                    pushed_next = 1'b1;
                    state_next  = ST_RECON;
                end
            end
            ST_EMIT: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = out_val;
                    msat_next  = out_ovf;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            mv_reg     <= 1'b0;
            root_reg   <= '0;
            pushed_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cnt_reg    <= cnt_next;
            pv_reg     <= pv_next;
            mv_reg     <= mv_next;
            root_reg   <= root_next;
            pushed_reg <= pushed_next;
        end
        kind_reg  <= kind_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        val_reg   <= val_next;
        depth_reg <= depth_next;
        acc_reg   <= acc_next;
        run_reg   <= run_next;
        pnx_reg   <= pnx_next;
        pny_reg   <= pny_next;
        paddr_reg <= paddr_next;
        pq_reg    <= pq_next;
        mdata_reg <= mdata_next;
        msat_reg  <= msat_next;
    end

    `HQPS_ASSERT_NOW(a_rmw_no_overlap, aclk, aresetn, ram_we && ram_re, ram_waddr != ram_raddr)
    `HQPS_ASSERT_NOW(a_pipe_from_walk, aclk, aresetn, pv_reg, $past(state_reg == ST_RECON || state_reg == ST_PUSH))
    `HQPS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `HQPS_ASSERT_NOW(a_walk_bound, aclk, aresetn, state_reg == ST_RECON, cnt_reg <= depth_reg)

endmodule

`default_nettype wire
